// File: rtl/ptt_pkg.sv
// Shared types and codes of the programmable transition table.
package ptt_pkg;

    localparam int FieldW = 4;
    localparam int KindW  = 3;
    localparam int CondW  = 3;

    localparam logic [1:0] CMD_ADD_NODE = 2'd0;
    localparam logic [1:0] CMD_ADD_EDGE = 2'd1;
    localparam logic [1:0] CMD_NEXT     = 2'd2;
    localparam logic [1:0] CMD_VALIDATE = 2'd3;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NODES_FULL  = 4'd1;
    localparam logic [3:0] ST_BAD_NODE    = 4'd2;
    localparam logic [3:0] ST_DUPLICATE   = 4'd3;
    localparam logic [3:0] ST_EDGES_FULL  = 4'd4;
    localparam logic [3:0] ST_NO_TRANS    = 4'd5;
    localparam logic [3:0] ST_EMPTY       = 4'd6;
    localparam logic [3:0] ST_MISSING_OP  = 4'd7;
    localparam logic [3:0] ST_UNREACHABLE = 4'd8;

    localparam logic [KindW-1:0] OP_DRAFT  = 3'd0;
    localparam logic [KindW-1:0] OP_VERIFY = 3'd1;
    localparam logic [KindW-1:0] OP_COMMIT = 3'd4;
    localparam logic [KindW-1:0] OP_STOP   = 3'd5;

    localparam logic [CondW-1:0] COND_ALWAYS = 3'd0;

    typedef struct packed {
        logic [FieldW-1:0] from_node;
        logic [FieldW-1:0] to_node;
        logic [CondW-1:0]  condition;
    } t_edge;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// File: rtl/ptt_edge_cell.sv
// One cell of the edge ring: holds one edge and hands it to its neighbor.
module ptt_edge_cell (
    input  logic              i_clk,
    input  ptt_pkg::t_cell_ctl i_ctl,
    input  ptt_pkg::t_edge    i_prev,
    input  ptt_pkg::t_edge    i_load,
    output ptt_pkg::t_edge    o_entry
);
    import ptt_pkg::*;

    t_edge r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_load;
        end else if (i_ctl.shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;
endmodule

// File: rtl/ptt_visit_queue.sv
// Work queue memory of the reachability walk, registered read.
module ptt_visit_queue #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [3:0]               i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [3:0]               o_rd_data
);
    logic [3:0] r_mem [DEPTH];
    logic [3:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/programmable_transition_table_core.sv
// Top level of the programmable transition table.
//
// channel  dir  handshake               payload
// s        in   i_s_tvalid/o_s_tready   i_s_tdata  command item
// m        out  o_m_tvalid/i_m_tready   o_m_tdata  result item
//
// Add edge and next lookup rotate the ring of cells that holds the edges once
// past the head cell, one edge per cycle. Validate makes one ring rotation per
// node taken off the queue.
// Reset is synchronous, active low, and clears the counters and control.
// One item is in work at a time; a result waiting on o_m stalls only the
// item after it.
module programmable_transition_table_core #(
    parameter int MAX_NODES = 16,
    parameter int MAX_EDGES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // cmd[1:0] op_kind[4:2] from_node[8:5] to_node[12:9] condition[15:13]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // ok[0] node_id[4:1] status[8:5], zero above
);
    import ptt_pkg::*;

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int NIW = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int IW  = $clog2(MAX_EDGES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_POP   = 5'b00100,
        S_STORE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state;
    logic [1:0]        r_cmd;
    logic [3:0]        r_from;
    logic [3:0]        r_to;
    logic [2:0]        r_cond;
    logic [NW-1:0]     r_node_total;
    logic [EW-1:0]     r_edge_total;
    logic [7:0]        r_has;
    logic [IW-1:0]     r_cnt;
    logic              r_fx;
    logic [3:0]        r_fx_to;
    logic              r_fa;
    logic [3:0]        r_fa_to;
    logic [MAX_NODES-1:0] r_reached;
    logic [NW-1:0]     r_q_head;
    logic [NW-1:0]     r_q_tail;
    logic              r_res_ok;
    logic [3:0]        r_res_id;
    logic [3:0]        r_res_st;
    logic              r_m_valid;
    logic [15:0]       r_m_data;

    t_edge     w_cell [MAX_EDGES];
    t_cell_ctl w_ctl  [MAX_EDGES];
    t_edge     w_load;
    t_edge     w_head;

    logic           w_accept;
    logic [1:0]     w_cmd;
    logic [2:0]     w_op;
    logic [3:0]     w_from;
    logic [3:0]     w_to;
    logic [2:0]     w_cond;
    logic           w_node_ok;
    logic           w_valid;
    logic           w_from_hit;
    logic           w_exact;
    logic           w_alw;
    logic           w_fx_now;
    logic [3:0]     w_fx_to_now;
    logic           w_fa_now;
    logic [3:0]     w_fa_to_now;
    logic           w_last;
    logic [NIW-1:0] w_to_idx;
    logic           w_bfs_hit;
    logic [3:0]     w_q_rdata;
    logic           w_q_wr_en;
    logic [NIW-1:0] w_q_wr_addr;
    logic [3:0]     w_q_wr_data;
    logic           w_q_rd_en;
    logic           w_out_free;

    assign w_cmd  = i_s_tdata[1:0];
    assign w_op   = i_s_tdata[4:2];
    assign w_from = i_s_tdata[8:5];
    assign w_to   = i_s_tdata[12:9];
    assign w_cond = i_s_tdata[15:13];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_node_ok  = (w_cmd == CMD_ADD_NODE) && (r_node_total < NW'(MAX_NODES));

    assign w_load = '{from_node: r_from, to_node: r_to, condition: r_cond};

    // Ring rotates toward cell 0; cell 0 is the head that control examines.
    for (genvar g = 0; g < MAX_EDGES; g++) begin : g_cell
        assign w_ctl[g].shift = (r_state == S_SCAN);
        assign w_ctl[g].load  = (r_state == S_STORE) &&
                                (r_edge_total[IW-1:0] == IW'(g));
        ptt_edge_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_prev  (w_cell[(g + 1) % MAX_EDGES]),
            .i_load  (w_load),
            .o_entry (w_cell[g])
        );
    end

    assign w_head      = w_cell[0];
    assign w_valid     = EW'(r_cnt) < r_edge_total;
    assign w_from_hit  = w_valid && (w_head.from_node == r_from);
    assign w_exact     = w_from_hit && (w_head.condition == r_cond);
    assign w_alw       = w_from_hit && (w_head.condition == COND_ALWAYS);
    assign w_fx_now    = r_fx || w_exact;
    assign w_fx_to_now = r_fx ? r_fx_to : w_head.to_node;
    assign w_fa_now    = r_fa || w_alw;
    assign w_fa_to_now = r_fa ? r_fa_to : w_head.to_node;
    assign w_last      = (r_cnt == IW'(MAX_EDGES - 1));
    assign w_to_idx    = NIW'(w_head.to_node);
    assign w_bfs_hit   = (r_state == S_SCAN) && (r_cmd == CMD_VALIDATE) && w_valid &&
                         (w_head.from_node == w_q_rdata) && !r_reached[w_to_idx];

    always_comb begin
        w_q_wr_en   = 1'b0;
        w_q_wr_addr = r_q_tail[NIW-1:0];
        w_q_wr_data = w_head.to_node;
        if (w_bfs_hit) begin
            w_q_wr_en = 1'b1;
        end else if (w_accept && (w_cmd == CMD_VALIDATE)) begin
            w_q_wr_en   = 1'b1;
            w_q_wr_addr = '0;
            w_q_wr_data = 4'd0;
        end
    end

    assign w_q_rd_en = (r_state == S_POP) && (r_q_head < r_q_tail);

    ptt_visit_queue #(.DEPTH(MAX_NODES)) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (w_q_wr_en),
        .i_wr_addr (w_q_wr_addr),
        .i_wr_data (w_q_wr_data),
        .i_rd_en   (w_q_rd_en),
        .i_rd_addr (r_q_head[NIW-1:0]),
        .o_rd_data (w_q_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_total <= '0;
            r_edge_total <= '0;
            r_has        <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= w_cmd;
                        r_from   <= w_from;
                        r_to     <= w_to;
                        r_cond   <= w_cond;
                        r_cnt    <= '0;
                        r_fx     <= 1'b0;
                        r_fa     <= 1'b0;
                        r_res_ok <= w_node_ok;
                        r_res_id <= w_node_ok ? 4'(r_node_total) : 4'd0;
                        case (w_cmd)
                            CMD_ADD_NODE: begin
                                r_state <= S_DONE;
                                if (r_node_total >= NW'(MAX_NODES)) begin
                                    r_res_st <= ST_NODES_FULL;
                                end else begin
                                    r_res_st     <= ST_OK;
                                    r_has[w_op]  <= 1'b1;
                                    r_node_total <= r_node_total + 1'b1;
                                end
                            end
                            CMD_ADD_EDGE: begin
                                if ((NW'(w_from) >= r_node_total) ||
                                    (NW'(w_to) >= r_node_total) ||
                                    ((MAX_NODES < 16) &&
                                     ((w_from >= 4'(MAX_NODES)) ||
                                      (w_to >= 4'(MAX_NODES))))) begin
                                    r_res_st <= ST_BAD_NODE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_NEXT: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                if (r_node_total == '0) begin
                                    r_res_st <= ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else if (!r_has[OP_DRAFT] || !r_has[OP_VERIFY] ||
                                             !r_has[OP_COMMIT] || !r_has[OP_STOP]) begin
                                    r_res_st <= ST_MISSING_OP;
                                    r_state  <= S_DONE;
                                end else begin
                                    // Node 0 starts reached.
                                    r_reached    <= MAX_NODES'(1);
                                    r_q_head     <= '0;
                                    r_q_tail     <= NW'(1);
                                    r_state      <= S_POP;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_cnt   <= w_last ? '0 : r_cnt + 1'b1;
                    r_fx    <= w_fx_now && !w_last;
                    r_fx_to <= w_fx_to_now;
                    r_fa    <= w_fa_now && !w_last;
                    r_fa_to <= w_fa_to_now;
                    if (w_bfs_hit) begin
                        r_reached[w_to_idx] <= 1'b1;
                        r_q_tail            <= r_q_tail + 1'b1;
                    end
                    if (w_last) begin
                        case (r_cmd)
                            CMD_ADD_EDGE: begin
                                if (w_fx_now) begin
                                    r_res_st <= ST_DUPLICATE;
                                    r_state  <= S_DONE;
                                end else if (r_edge_total >= EW'(MAX_EDGES)) begin
                                    r_res_st <= ST_EDGES_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_res_ok <= 1'b1;
                                    r_res_st <= ST_OK;
                                    r_state  <= S_STORE;
                                end
                            end
                            CMD_NEXT: begin
                                r_state <= S_DONE;
                                if (w_fx_now) begin
                                    r_res_ok <= 1'b1;
                                    r_res_id <= w_fx_to_now;
                                    r_res_st <= ST_OK;
                                end else if (w_fa_now) begin
                                    r_res_ok <= 1'b1;
                                    r_res_id <= w_fa_to_now;
                                    r_res_st <= ST_OK;
                                end else begin
                                    r_res_st <= ST_NO_TRANS;
                                end
                            end
                            default: begin
                                r_state <= S_POP;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    // Read data lands in time for the start of the rotation.
                    if (r_q_head < r_q_tail) begin
                        r_q_head <= r_q_head + 1'b1;
                        r_state  <= S_SCAN;
                    end else begin
                        r_res_ok <= (r_q_tail == r_node_total);
                        r_res_st <= (r_q_tail == r_node_total) ? ST_OK : ST_UNREACHABLE;
                        r_state  <= S_DONE;
                    end
                end
                S_STORE: begin
                    r_edge_total <= r_edge_total + 1'b1;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {7'd0, r_res_st, r_res_id, r_res_ok};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_edge_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_total <= EW'(MAX_EDGES))
        else $error("edge count beyond table depth");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmd == CMD_VALIDATE) |-> r_q_tail <= NW'(MAX_NODES))
        else $error("visit queue overrun");

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE) |-> (r_edge_total < EW'(MAX_EDGES)))
        else $error("edge store with full table");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second transaction taken while busy");
endmodule
